FILE: hw/rtl/abt_pkg.sv
// Shared types and constants for the allocation block tracker.
`default_nettype none
package abt_pkg;

    // field widths of the stream payload
    localparam int CMD_W         = 2;
    localparam int ADDR_FIELD_W  = 32;
    localparam int LEN_FIELD_W   = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 7;
    localparam int IN_TDATA_W    = 64;
    localparam int OUT_TDATA_W   = 40;

    // defaults for the top level parameters
    localparam int TABLE_DEPTH_DEF  = 64;
    localparam int ADDR_WIDTH_DEF   = 32;
    localparam int LENGTH_WIDTH_DEF = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_DEL    = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_ZERO      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } t_state;

    // result of the shared key comparator
    typedef struct packed {
        logic eq;
        logic ge;
    } t_cmp_res;

endpackage
`default_nettype wire

FILE: hw/rtl/abt_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module abt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: hw/rtl/abt_cmp.sv
// Shared key comparator: table entry address against the command address.
`default_nettype none
module abt_cmp
    import abt_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  wire logic [ADDR_WIDTH-1:0] i_entry_addr,
    input  wire logic [ADDR_WIDTH-1:0] i_key_addr,
    output t_cmp_res                   o_res
);

    always_comb begin
        o_res.eq = (i_entry_addr == i_key_addr);
        o_res.ge = (i_entry_addr >= i_key_addr);
    end

endmodule
`default_nettype wire

FILE: hw/rtl/allocation_block_tracker.sv
// Top level of the allocation block tracker: sequencer, table RAM and comparator.
//
// Keeps up to TABLE_DEPTH blocks (start address, length) sorted by address in one
// RAM and walks it one entry per clock through a single comparator. An add walks
// every held entry and then the free slot at the end, rippling every entry from the
// insertion point on up one place. A delete always walks every held entry; a lookup
// stops at the first match. Rejected adds, unused command codes, and deletes and
// lookups on an empty table skip the walk and go straight to the result.
// One command is worked at a time; the next beat is taken while a finished result
// still waits on the output, but that command cannot finish until the waiting
// result has gone.
`default_nettype none
module allocation_block_tracker
    import abt_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF,
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // block_address, block_length
    input  wire logic [CMD_W-1:0]       i_s_axis_tuser,  // cmd
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,  // found_length, entry_count, pad
    output logic [STATUS_W-1:0]         o_m_axis_tuser   // status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = ADDR_WIDTH + LENGTH_WIDTH;

    t_state                  r_state, n_state;
    t_cmd                    r_cmd, n_cmd;
    t_status                 r_status, n_status;
    logic [ADDR_WIDTH-1:0]   r_addr, n_addr;
    logic [LENGTH_WIDTH-1:0] r_len, n_len;
    logic [LENGTH_WIDTH-1:0] r_found, n_found;
    logic [EW-1:0]           r_carry, n_carry;
    logic [CW-1:0]           r_idx, n_idx;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_hit, n_hit;
    logic                    r_out_valid, n_out_valid;
    t_status                 r_out_status, n_out_status;
    logic [LEN_FIELD_W-1:0]  r_out_found, n_out_found;
    logic [COUNT_FIELD_W-1:0] r_out_count, n_out_count;

    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic [EW-1:0]           w_wdata;
    logic [AW-1:0]           w_raddr;
    logic [EW-1:0]           w_rdata;
    logic [ADDR_WIDTH-1:0]   w_rd_addr;
    logic [LENGTH_WIDTH-1:0] w_rd_len;
    logic [ADDR_WIDTH-1:0]   w_in_addr;
    logic [LENGTH_WIDTH-1:0] w_in_len;
    logic [CW-1:0]           w_idx_inc;
    logic                    w_is_end;
    logic                    w_is_last;
    t_cmp_res                w_cmp;

    assign w_in_addr = ADDR_WIDTH'(i_s_axis_tdata[ADDR_FIELD_W-1:0]);
    assign w_in_len  = LENGTH_WIDTH'(i_s_axis_tdata[ADDR_FIELD_W +: LEN_FIELD_W]);
    assign w_rd_addr = w_rdata[EW-1 -: ADDR_WIDTH];
    assign w_rd_len  = w_rdata[LENGTH_WIDTH-1:0];
    assign w_idx_inc = r_idx + 1'b1;
    assign w_is_end  = (r_idx == r_count);
    assign w_is_last = (w_idx_inc == r_count);
    // next entry is fetched while the current one is being worked
    assign w_raddr   = (r_state == S_SCAN) ? w_idx_inc[AW-1:0] : '0;

    abt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    abt_cmp #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_cmp (
        .i_entry_addr (w_rd_addr),
        .i_key_addr   (r_addr),
        .o_res        (w_cmp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_status     <= n_status;
        r_addr       <= n_addr;
        r_len        <= n_len;
        r_found      <= n_found;
        r_carry      <= n_carry;
        r_idx        <= n_idx;
        r_hit        <= n_hit;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_count  <= n_out_count;
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_status     = r_status;
        n_addr       = r_addr;
        n_len        = r_len;
        n_found      = r_found;
        n_carry      = r_carry;
        n_idx        = r_idx;
        n_count      = r_count;
        n_hit        = r_hit;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_count  = r_out_count;
        w_we         = 1'b0;
        w_waddr      = r_idx[AW-1:0];
        w_wdata      = r_carry;

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_cmd    = t_cmd'(i_s_axis_tuser);
                    n_addr   = w_in_addr;
                    n_len    = w_in_len;
                    n_found  = '0;
                    n_idx    = '0;
                    n_hit    = 1'b0;
                    n_status = ST_OK;
                    n_state  = S_SCAN;
                    case (t_cmd'(i_s_axis_tuser))
                        CMD_ADD: begin
                            if (w_in_addr == '0 || w_in_len == '0) begin
                                n_status = ST_ZERO;
                                n_state  = S_DONE;
                            end else if (r_count >= CW'(TABLE_DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end
                        end
                        CMD_DEL, CMD_LOOKUP: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                                n_state  = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_idx = w_idx_inc;
                case (r_cmd)
                    CMD_ADD: begin
                        // new entry goes in ahead of the first equal or greater
                        // address; everything after ripples up one place
                        w_we    = 1'b1;
                        n_carry = w_rdata;
                        if (!r_hit && (w_is_end || w_cmp.ge)) begin
                            w_wdata = {r_addr, r_len};
                            n_hit   = 1'b1;
                        end else if (!r_hit) begin
                            w_we = 1'b0;
                        end
                        if (w_is_end) begin
                            n_count = r_count + 1'b1;
                            n_state = S_DONE;
                        end
                    end
                    CMD_DEL: begin
                        // past the match, every entry moves down one place
                        if (r_hit) begin
                            w_we    = 1'b1;
                            w_waddr = AW'(r_idx - 1'b1);
                            w_wdata = w_rdata;
                        end else if (w_cmp.eq) begin
                            n_hit = 1'b1;
                        end
                        if (w_is_last) begin
                            n_state = S_DONE;
                            if (r_hit || w_cmp.eq) begin
                                n_count = r_count - 1'b1;
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                    end
                    CMD_LOOKUP: begin
                        if (w_cmp.eq) begin
                            n_found = w_rd_len;
                            n_state = S_DONE;
                        end else if (w_is_last) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = LEN_FIELD_W'(r_found);
                    n_out_count  = COUNT_FIELD_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_count, r_out_found});

endmodule
`default_nettype wire

FILE: hw/rtl/abt_chk.sv
// Port-level checks for the allocation block tracker, bound to the top level.
`default_nettype none
module abt_chk
    import abt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_axis_tvalid,
    input wire logic                   o_s_axis_tready,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic [STATUS_W-1:0]    o_m_axis_tuser
);

    // no result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // one command at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while a command is in work");

    // only a good lookup reports a length
    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_OK |-> o_m_axis_tdata[LEN_FIELD_W-1:0] == '0)
        else $error("length reported on failed command");

    // a full rejection reports a full table
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_FULL |->
            o_m_axis_tdata[LEN_FIELD_W +: COUNT_FIELD_W] == COUNT_FIELD_W'(TABLE_DEPTH))
        else $error("table full reported with room left");

endmodule

bind allocation_block_tracker abt_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_abt_chk (.*);
`default_nettype wire
